[rtl/core/mmpq_pkg.sv]
// shared types and constants for the mergeable min priority queue
// no dependencies; imported by every module of the block except the ram
package mmpq_pkg;

    localparam int KEY_W        = 32;
    localparam int KIND_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int SIZE_W       = 7;
    localparam int DEF_CAPACITY = 64;

    // stream widths
    localparam int S_TDATA_W = 2 * KEY_W;
    localparam int S_TUSER_W = KIND_W + 1;
    localparam int M_TDATA_W = ((KEY_W + SIZE_W + 7) / 8) * 8;
    localparam int M_TUSER_W = STATUS_W;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT      = 3'd0,
        KIND_FIND_MIN    = 3'd1,
        KIND_EXTRACT_MIN = 3'd2,
        KIND_DECREASE    = 3'd3,
        KIND_REMOVE      = 3'd4,
        KIND_UNION       = 3'd5
    } kind_t;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_EMPTY       = 3'd1,
        ST_EXISTS      = 3'd2,
        ST_MISSING     = 3'd3,
        ST_FULL        = 3'd4,
        ST_NOT_SMALLER = 3'd5
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the accepted item, clear scan results
        logic scan_rd;  // read the slot at the scan address
        logic commit;   // apply the operation and load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_needed;  // latched kind walks the slot store
    } dp_status_t;

endpackage

[rtl/core/mmpq_ram.sv]
// generic simple dual port ram with registered read
// no dependencies
module mmpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mmpq_ctrl.sv]
// controller: handshakes, slot scan counter and operation sequencing
// depends on mmpq_pkg
module mmpq_ctrl #(
    parameter int CAPACITY = mmpq_pkg::DEF_CAPACITY,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  mmpq_pkg::dp_status_t dp_status,
    output mmpq_pkg::ctrl_cmd_t  cmd,
    output logic [IDX_W-1:0]     scan_addr
);

    import mmpq_pkg::*;

    localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [IDX_W:0]  cnt_reg, cnt_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!dp_status.scan_needed || cnt_reg == SCAN_END)
                begin
                    state_next = S_COMMIT;
                end
                else
                begin
                    cmd.scan_rd = 1'b1;
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit    = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign scan_addr = cnt_reg[IDX_W-1:0];

endmodule

[rtl/core/mmpq_dp.sv]
// datapath: key store, slot valid bits, heap counts, scan and commit logic
// depends on mmpq_pkg and mmpq_ram
module mmpq_dp #(
    parameter int CAPACITY = mmpq_pkg::DEF_CAPACITY,
    localparam int IDX_W   = $clog2(CAPACITY)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mmpq_pkg::ctrl_cmd_t              cmd,
    input  logic [IDX_W-1:0]                 scan_addr,
    output mmpq_pkg::dp_status_t             dp_status,
    input  logic [mmpq_pkg::KIND_W-1:0]      in_kind,
    input  logic                             in_heap_sel,
    input  logic signed [mmpq_pkg::KEY_W-1:0] in_key,
    input  logic signed [mmpq_pkg::KEY_W-1:0] in_new_key,
    output logic [mmpq_pkg::STATUS_W-1:0]    out_status,
    output logic signed [mmpq_pkg::KEY_W-1:0] out_min_key,
    output logic [mmpq_pkg::SIZE_W-1:0]      out_heap_size
);

    import mmpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int RAM_W = KEY_W + 1;

    // latched item
    kind_t                    kind_reg;
    logic                     sel_reg;
    logic signed [KEY_W-1:0]  key_reg;
    logic signed [KEY_W-1:0]  nkey_reg;

    // slot state
    logic [CAPACITY-1:0]      valid_reg, valid_next;
    logic [CNT_W-1:0]         count_reg [2];
    logic [CNT_W-1:0]         count_next [2];

    // read pipeline
    logic                     pv_reg;
    logic [IDX_W-1:0]         pidx_reg;
    logic [RAM_W-1:0]         rd_data;
    logic signed [KEY_W-1:0]  e_key;
    logic                     e_heap;
    logic                     slot_v;

    // scan results
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic                     hit_heap_reg, hit_heap_next;
    logic                     nhit_reg, nhit_next;
    logic                     free_reg, free_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     min_reg, min_next;
    logic [IDX_W-1:0]         min_idx_reg, min_idx_next;
    logic signed [KEY_W-1:0]  min_key_reg, min_key_next;

    // ram write port
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [RAM_W-1:0]         wr_data;

    // commit decisions
    status_t                  c_status;
    logic signed [KEY_W-1:0]  c_min_key;
    logic                     set_en, clr_en;
    logic [IDX_W-1:0]         set_idx, clr_idx;

    // result register
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [KEY_W-1:0]  out_min_key_reg;
    logic [SIZE_W-1:0]        out_size_reg;

    mmpq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.scan_rd),
        .rd_addr (scan_addr),
        .rd_data (rd_data)
    );

    assign e_key  = rd_data[KEY_W-1:0];
    assign e_heap = rd_data[KEY_W];
    assign slot_v = valid_reg[pidx_reg];

    assign dp_status.scan_needed = (kind_reg == KIND_INSERT)
                                || (kind_reg == KIND_FIND_MIN)
                                || (kind_reg == KIND_EXTRACT_MIN)
                                || (kind_reg == KIND_DECREASE)
                                || (kind_reg == KIND_REMOVE)
                                || (kind_reg == KIND_UNION);

    // one slot per cycle: key matches, first free slot, running minimum
    always_comb
    begin
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_heap_next = hit_heap_reg;
        nhit_next     = nhit_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        min_next      = min_reg;
        min_idx_next  = min_idx_reg;
        min_key_next  = min_key_reg;
        if (cmd.load)
        begin
            hit_next  = 1'b0;
            nhit_next = 1'b0;
            free_next = 1'b0;
            min_next  = 1'b0;
        end
        else if (pv_reg)
        begin
            if (slot_v && e_key == key_reg)
            begin
                hit_next      = 1'b1;
                hit_idx_next  = pidx_reg;
                hit_heap_next = e_heap;
            end
            if (slot_v && e_key == nkey_reg)
            begin
                nhit_next = 1'b1;
            end
            if (!slot_v && !free_reg)
            begin
                free_next     = 1'b1;
                free_idx_next = pidx_reg;
            end
            if (slot_v && e_heap == sel_reg && (!min_reg || e_key < min_key_reg))
            begin
                min_next     = 1'b1;
                min_idx_next = pidx_reg;
                min_key_next = e_key;
            end
        end
    end

    // operation decode at commit
    always_comb
    begin
        c_status      = ST_OK;
        c_min_key     = '0;
        set_en        = 1'b0;
        set_idx       = free_idx_reg;
        clr_en        = 1'b0;
        clr_idx       = hit_idx_reg;
        count_next[0] = count_reg[0];
        count_next[1] = count_reg[1];
        unique case (kind_reg)
            KIND_INSERT:
            begin
                if (hit_reg)
                begin
                    c_status = ST_EXISTS;
                end
                else if (!free_reg)
                begin
                    c_status = ST_FULL;
                end
                else
                begin
                    set_en              = 1'b1;
                    count_next[sel_reg] = count_reg[sel_reg] + 1'b1;
                end
            end
            KIND_FIND_MIN, KIND_EXTRACT_MIN:
            begin
                if (!min_reg)
                begin
                    c_status = ST_EMPTY;
                end
                else
                begin
                    c_min_key = min_key_reg;
                    if (kind_reg == KIND_EXTRACT_MIN)
                    begin
                        clr_en              = 1'b1;
                        clr_idx             = min_idx_reg;
                        count_next[sel_reg] = count_reg[sel_reg] - 1'b1;
                    end
                end
            end
            KIND_DECREASE:
            begin
                if (!hit_reg || hit_heap_reg != sel_reg)
                begin
                    c_status = ST_MISSING;
                end
                else if (!(nkey_reg < key_reg))
                begin
                    c_status = ST_NOT_SMALLER;
                end
                else if (nhit_reg)
                begin
                    c_status = ST_EXISTS;
                end
            end
            KIND_REMOVE:
            begin
                if (!hit_reg || hit_heap_reg != sel_reg)
                begin
                    c_status = ST_MISSING;
                end
                else
                begin
                    clr_en              = 1'b1;
                    count_next[sel_reg] = count_reg[sel_reg] - 1'b1;
                end
            end
            KIND_UNION:
            begin
                count_next[sel_reg]  = count_reg[sel_reg] + count_reg[!sel_reg];
                count_next[!sel_reg] = '0;
            end
            default:
            begin
                c_status = ST_OK;
            end
        endcase
    end

    // ram write: relabel during a union scan, new key at commit
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pidx_reg;
        wr_data = {sel_reg, e_key};
        if (pv_reg && kind_reg == KIND_UNION && slot_v && e_heap != sel_reg)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.commit && set_en)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx_reg;
            wr_data = {sel_reg, key_reg};
        end
        else if (cmd.commit && kind_reg == KIND_DECREASE && c_status == ST_OK)
        begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
            wr_data = {sel_reg, nkey_reg};
        end
    end

    // valid bits
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit && set_en)
        begin
            valid_next[set_idx] = 1'b1;
        end
        if (cmd.commit && clr_en)
        begin
            valid_next[clr_idx] = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            pv_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pv_reg    <= cmd.scan_rd;
            if (cmd.commit)
            begin
                count_reg[0] <= count_next[0];
                count_reg[1] <= count_next[1];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg     <= scan_addr;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_heap_reg <= hit_heap_next;
        nhit_reg     <= nhit_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        min_reg      <= min_next;
        min_idx_reg  <= min_idx_next;
        min_key_reg  <= min_key_next;
        if (cmd.load)
        begin
            kind_reg <= kind_t'(in_kind);
            sel_reg  <= in_heap_sel;
            key_reg  <= in_key;
            nkey_reg <= in_new_key;
        end
        if (cmd.commit)
        begin
            out_status_reg  <= c_status;
            out_min_key_reg <= c_min_key;
            out_size_reg    <= SIZE_W'(count_next[sel_reg]);
        end
    end

    assign out_status    = out_status_reg;
    assign out_min_key   = out_min_key_reg;
    assign out_heap_size = out_size_reg;

endmodule

[rtl/core/mergeable_min_priority_queue.sv]
// two mergeable min priority queues over one shared store of unique keys
// one item at a time: an item is accepted only when idle, the key ram is then scanned
// one slot per cycle over every slot (unused kinds skip the scan), and the result
// is committed once the output register is free; the next item is taken while a
// result waits
// reset: asynchronous, active low; clears slot valid bits and both heap counts at once
module mergeable_min_priority_queue #(
    parameter int CAPACITY = mmpq_pkg::DEF_CAPACITY
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mmpq_pkg::S_TDATA_W-1:0]   s_tdata,  // key, new_key
    input  logic [mmpq_pkg::S_TUSER_W-1:0]   s_tuser,  // kind, heap_sel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mmpq_pkg::M_TDATA_W-1:0]   m_tdata,  // min_key, heap_size, zero fill
    output logic [mmpq_pkg::M_TUSER_W-1:0]   m_tuser   // status
);

    import mmpq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);

    ctrl_cmd_t                cmd;
    dp_status_t               dp_status;
    logic [IDX_W-1:0]         scan_addr;
    logic [STATUS_W-1:0]      status;
    logic signed [KEY_W-1:0]  min_key;
    logic [SIZE_W-1:0]        heap_size;

    mmpq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .dp_status (dp_status),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    mmpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .scan_addr     (scan_addr),
        .dp_status     (dp_status),
        .in_kind       (s_tuser[KIND_W-1:0]),
        .in_heap_sel   (s_tuser[KIND_W]),
        .in_key        (s_tdata[KEY_W-1:0]),
        .in_new_key    (s_tdata[2*KEY_W-1:KEY_W]),
        .out_status    (status),
        .out_min_key   (min_key),
        .out_heap_size (heap_size)
    );

    // result packing
    assign m_tdata = M_TDATA_W'({heap_size, min_key});
    assign m_tuser = status;

endmodule

[tb/tb_mergeable_min_priority_queue.sv]
// self-checking testbench for the two-heap mergeable min priority queue
// drives random and directed operations, predicts every result from its own heap model
// depends on mmpq_pkg and the mergeable_min_priority_queue rtl
module tb_mergeable_min_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import mmpq_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int POOL_N       = 96;
    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_LEN    = 100;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;
    localparam int QUIET_FROM   = 40000;
    localparam int QUIET_TO     = 60000;

    // random operation mixes
    localparam int MODE_MIXED = 0;
    localparam int MODE_FILL  = 1;
    localparam int MODE_DRAIN = 2;

    // kinds with no operation behind them
    localparam logic [KIND_W-1:0] KIND_NOP_LO = 3'd6;
    localparam logic [KIND_W-1:0] KIND_NOP_HI = 3'd7;

    // slot ownership tags
    localparam logic [1:0] SLOT_FREE = 2'd0;
    localparam logic [1:0] SLOT_H0   = 2'd1;
    localparam logic [1:0] SLOT_H1   = 2'd2;

    localparam logic signed [KEY_W-1:0] KEY_LO = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_HI = 32'sh7fff_ffff;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic                    sel;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] new_key;
    } heap_op_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [KEY_W-1:0] min_key;
        logic [SIZE_W-1:0]       size;
    } heap_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // key, new_key
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // kind, heap_sel
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // min_key, heap_size, zero fill
    logic [M_TUSER_W-1:0] m_tuser;         // status

    heap_op_t     op_queue [$];
    heap_result_t result_queue [$];
    logic signed [KEY_W-1:0] key_pool [POOL_N];

    // own model of the shared node store
    logic signed [KEY_W-1:0] node_key [CAP];
    logic [1:0]              node_owner [CAP];
    int unsigned             heap_cnt [2];

    int  cyc       = 0;
    int  quiet_cyc = 0;
    int  err_cnt   = 0;
    int  out_idx   = 0;
    bit  in_fire   = 1'b0;
    bit  timed_out = 1'b0;

    mergeable_min_priority_queue uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // slot holding a key in either heap, or -1
    function automatic int slot_of(input logic signed [KEY_W-1:0] k);
        for (int i = 0; i < CAP; i++)
            if (node_owner[i] != SLOT_FREE && node_key[i] == k)
                return i;
        return -1;
    endfunction

    // apply one operation to the model and return its result
    function automatic heap_result_t heap_apply(input heap_op_t op);
        heap_result_t r;
        int           s;
        logic [1:0]   tag;
        logic [1:0]   other;
        r.status  = ST_OK;
        r.min_key = '0;
        tag   = op.sel ? SLOT_H1 : SLOT_H0;
        other = op.sel ? SLOT_H0 : SLOT_H1;
        case (op.kind)
            KIND_INSERT:
            begin
                if (slot_of(op.key) >= 0)
                    r.status = ST_EXISTS;
                else
                begin
                    s = -1;
                    for (int i = 0; i < CAP; i++)
                        if (s < 0 && node_owner[i] == SLOT_FREE)
                            s = i;
                    if (s < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        node_key[s]   = op.key;
                        node_owner[s] = tag;
                        heap_cnt[op.sel]++;
                    end
                end
            end
            KIND_FIND_MIN, KIND_EXTRACT_MIN:
            begin
                s = -1;
                for (int i = 0; i < CAP; i++)
                    if (node_owner[i] == tag && (s < 0 || node_key[i] < node_key[s]))
                        s = i;
                if (s < 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.min_key = node_key[s];
                    if (op.kind == KIND_EXTRACT_MIN)
                    begin
                        node_owner[s] = SLOT_FREE;
                        heap_cnt[op.sel]--;
                    end
                end
            end
            KIND_DECREASE:
            begin
                s = slot_of(op.key);
                if (s < 0 || node_owner[s] != tag)
                    r.status = ST_MISSING;
                else if (!(op.new_key < op.key))
                    r.status = ST_NOT_SMALLER;
                else if (slot_of(op.new_key) >= 0)
                    r.status = ST_EXISTS;
                else
                    node_key[s] = op.new_key;
            end
            KIND_REMOVE:
            begin
                s = slot_of(op.key);
                if (s < 0 || node_owner[s] != tag)
                    r.status = ST_MISSING;
                else
                begin
                    node_owner[s] = SLOT_FREE;
                    heap_cnt[op.sel]--;
                end
            end
            KIND_UNION:
            begin
                for (int i = 0; i < CAP; i++)
                    if (node_owner[i] == other)
                        node_owner[i] = tag;
                heap_cnt[op.sel]  += heap_cnt[!op.sel];
                heap_cnt[!op.sel] = 0;
            end
            default: ;
        endcase
        r.size = SIZE_W'(heap_cnt[op.sel]);
        return r;
    endfunction

    function automatic void push_op(input logic [KIND_W-1:0] kind, input logic sel,
                                    input logic signed [KEY_W-1:0] key,
                                    input logic signed [KEY_W-1:0] new_key);
        heap_op_t op;
        op.kind    = kind;
        op.sel     = sel;
        op.key     = key;
        op.new_key = new_key;
        op_queue = {op_queue, op};
    endfunction

    // operation kind drawn from the mix of the current phase
    function automatic logic [KIND_W-1:0] pick_kind(input int mode);
        int cut [6];
        int roll;
        case (mode)
            MODE_FILL:  cut = '{85, 88, 91, 95, 97, 99};
            MODE_DRAIN: cut = '{10, 20, 65, 75, 92, 98};
            default:    cut = '{30, 42, 57, 75, 89, 97};
        endcase
        roll = $urandom_range(99);
        if (roll < cut[0]) return KIND_INSERT;
        if (roll < cut[1]) return KIND_FIND_MIN;
        if (roll < cut[2]) return KIND_EXTRACT_MIN;
        if (roll < cut[3]) return KIND_DECREASE;
        if (roll < cut[4]) return KIND_REMOVE;
        if (roll < cut[5]) return KIND_UNION;
        return $urandom_range(1) ? KIND_NOP_HI : KIND_NOP_LO;
    endfunction

    // mostly keys from the shared pool so that hits and collisions are common
    function automatic logic signed [KEY_W-1:0] pick_key(input int fresh_pct);
        if ($urandom_range(99) < fresh_pct)
            return $urandom;
        return key_pool[$urandom_range(POOL_N - 1)];
    endfunction

    function automatic void push_random(input int mode);
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic signed [KEY_W-1:0] nkey;
        int                      roll;
        kind = pick_kind(mode);
        key  = pick_key(mode == MODE_FILL ? 45 : 15);
        nkey = $urandom;
        if (kind == KIND_DECREASE)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
                nkey = key_pool[$urandom_range(POOL_N - 1)];
            else if (roll < 85)
                nkey = key - $urandom_range(300, 1);
        end
        push_op(kind, 1'($urandom_range(1)), key, nkey);
    endfunction

    function automatic bit take_break();
        if (cyc >= QUIET_FROM && cyc < QUIET_TO)
            return 1'b0;
        return $urandom_range(99) < 22;
    endfunction

    // item driver, fed from the op queue
    always @(negedge clk)
    begin : drive_proc
        heap_op_t op;
        if (rst_n)
        begin
            m_tready <= !take_break();
            if (!s_tvalid || in_fire)
            begin
                if (op_queue.size() != 0 && !take_break())
                begin
                    op = op_queue.pop_front();
                    s_tdata  <= {op.new_key, op.key};
                    s_tuser  <= {op.sel, op.kind};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // prediction on input accept, checking on output accept, stall watchdog
    always @(posedge clk)
    begin : score_proc
        heap_op_t     op;
        heap_result_t exp_r;
        logic [SIZE_W-1:0] got_size;
        cyc     <= cyc + 1;
        in_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            op.kind    = s_tuser[KIND_W-1:0];
            op.sel     = s_tuser[KIND_W];
            op.key     = s_tdata[KEY_W-1:0];
            op.new_key = s_tdata[2*KEY_W-1:KEY_W];
            exp_r      = heap_apply(op);
            result_queue = {result_queue, exp_r};
        end
        if (m_tvalid && m_tready)
        begin
            got_size = m_tdata[KEY_W +: SIZE_W];
            if (result_queue.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected item status %0d min_key %0d size %0d",
                         $time, m_tuser, $signed(m_tdata[KEY_W-1:0]), got_size);
            end
            else
            begin
                exp_r = result_queue.pop_front();
                if (m_tuser !== exp_r.status)
                begin
                    err_cnt++;
                    $display("%0t: item %0d status expected %0d got %0d",
                             $time, out_idx, exp_r.status, m_tuser);
                end
                if (m_tdata[KEY_W-1:0] !== exp_r.min_key)
                begin
                    err_cnt++;
                    $display("%0t: item %0d min_key expected %0d got %0d",
                             $time, out_idx, exp_r.min_key,
                             $signed(m_tdata[KEY_W-1:0]));
                end
                if (got_size !== exp_r.size)
                begin
                    err_cnt++;
                    $display("%0t: item %0d heap_size expected %0d got %0d",
                             $time, out_idx, exp_r.size, got_size);
                end
            end
            out_idx++;
        end
        // cycles with no item moving on either side
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= STALL_LIMIT)
            timed_out <= 1'b1;
    end

    initial
    begin
        int mode;
        // key pool: extremes, a dense small range and wide random values
        key_pool[0] = KEY_LO;
        key_pool[1] = KEY_HI;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (int i = 5; i < POOL_N; i++)
            key_pool[i] = (i % 2) ? $urandom : $signed($urandom_range(200)) - 100;
        for (int i = 0; i < CAP; i++)
        begin
            node_key[i]   = '0;
            node_owner[i] = SLOT_FREE;
        end
        heap_cnt[0] = 0;
        heap_cnt[1] = 0;

        // directed: empty heaps, missing keys, extremes, every decrease outcome, unions
        push_op(KIND_FIND_MIN,    1'b0, 0, 0);
        push_op(KIND_EXTRACT_MIN, 1'b1, 0, 0);
        push_op(KIND_REMOVE,      1'b0, 3, 0);
        push_op(KIND_DECREASE,    1'b1, 3, 1);
        push_op(KIND_INSERT,      1'b0, KEY_HI, KEY_LO);
        push_op(KIND_INSERT,      1'b0, KEY_LO, KEY_HI);
        push_op(KIND_INSERT,      1'b1, KEY_LO, 0);
        push_op(KIND_INSERT,      1'b1, 0, -1);
        push_op(KIND_INSERT,      1'b1, -1, 0);
        push_op(KIND_FIND_MIN,    1'b0, -1, -1);
        push_op(KIND_DECREASE,    1'b1, KEY_HI, 5);
        push_op(KIND_DECREASE,    1'b0, KEY_HI, KEY_HI);
        push_op(KIND_DECREASE,    1'b0, KEY_HI, 0);
        push_op(KIND_DECREASE,    1'b0, KEY_HI, 5);
        push_op(KIND_DECREASE,    1'b0, KEY_LO, KEY_HI);
        push_op(KIND_REMOVE,      1'b0, 0, 0);
        push_op(KIND_REMOVE,      1'b0, 5, 0);
        push_op(KIND_UNION,       1'b1, KEY_HI, KEY_LO);
        push_op(KIND_UNION,       1'b1, 0, 0);
        push_op(KIND_NOP_LO,      1'b0, KEY_LO, KEY_HI);
        push_op(KIND_NOP_HI,      1'b1, KEY_HI, KEY_LO);
        push_op(KIND_FIND_MIN,    1'b1, 0, 0);
        push_op(KIND_EXTRACT_MIN, 1'b1, 0, 0);
        push_op(KIND_EXTRACT_MIN, 1'b1, 0, 0);
        push_op(KIND_UNION,       1'b0, 0, 0);
        push_op(KIND_EXTRACT_MIN, 1'b0, 0, 0);

        // random phases, the first one is insert heavy to fill the store
        mode = MODE_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n != 0 && n % PHASE_LEN == 0)
                mode = $urandom_range(MODE_DRAIN);
            push_random(mode);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!timed_out && (op_queue.size() != 0 || s_tvalid || result_queue.size() != 0))
            @(posedge clk);
        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);

        if (timed_out)
            $display("tb: failure");
        else if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
rtl/core/mmpq_pkg.sv
rtl/core/mmpq_ram.sv
rtl/core/mmpq_ctrl.sv
rtl/core/mmpq_dp.sv
rtl/core/mergeable_min_priority_queue.sv
tb/tb_mergeable_min_priority_queue.sv
